FILE: design/ars_pkg.sv
// Shared constants and codes for the axis response shaper.
`default_nettype none

package ars_pkg;

   // Default configuration of the shaping arithmetic
   localparam int ARS_FULL_SCALE         = 350;
   localparam int ARS_GAIN_FRACTION_BITS = 8;

   // Fixed field widths
   localparam int ARS_RAW_W    = 16;
   localparam int ARS_MAG_W    = ARS_RAW_W + 1;
   localparam int ARS_OUT_W    = 10;
   localparam int ARS_SENS_W   = 12;
   localparam int ARS_CURVE_W  = 3;
   localparam int ARS_GATE_W   = 9;
   localparam int ARS_CSR_IDX_W = 3;
   localparam int ARS_CSR_DAT_W = 12;

   // Fixed-point format of the tangent table generator
   localparam int ARS_QBITS        = 52;
   localparam int ARS_SERIES_TERMS = 13;

   // Response curve codes; anything else acts as linear
   typedef enum logic [ARS_CURVE_W-1:0] {
      CURVE_LINEAR  = 3'd0,
      CURVE_SQUARED = 3'd1,
      CURVE_TAN     = 3'd2,
      CURVE_SQ_TAN  = 3'd3,
      CURVE_CUBE_TAN = 3'd4
   } curve_type;

   // Register indexes of the configuration port
   typedef enum logic [ARS_CSR_IDX_W-1:0] {
      CSR_POS_SENS  = 3'd0,
      CSR_NEG_SENS  = 3'd1,
      CSR_POS_CURVE = 3'd2,
      CSR_NEG_CURVE = 3'd3,
      CSR_POS_GATE  = 3'd4,
      CSR_NEG_GATE  = 3'd5,
      CSR_INVERT    = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [ARS_SENS_W-1:0] ARS_SENS_RESET = 12'd256;

endpackage

`default_nettype wire

FILE: design/axis_response_shaper_unit.sv
// Axis response shaper: gain, response curve, dead band and inversion pipeline.
//
//  channel   direction  handshake          payload
//  req       in         req_valid/stall    req_raw_sample    (16 bit signed)
//  rsp       out        rsp_valid/stall    rsp_motion_value  (10 bit signed)
//  csr       in         csr_valid/ready    csr_index, csr_data
//
// One item per cycle sustained while rsp is not stalled; an accepted item reaches the
// result register through four register stages: side select, gain multiply and
// clamp, curve ROM read, gate and sign.
// The curve ROM holds the squared, tangent, squared tangent and cubed tangent curves, built at elaboration.
// Reset clears the pipeline valids and loads the register defaults; the ROM
// needs no fill. A stall on rsp holds the result and lets items fill bubbles
// upstream; req_stall rises only when every stage holds an item.
`default_nettype none

module axis_response_shaper_unit
   import ars_pkg::*;
#(
   parameter int FULL_SCALE         = ARS_FULL_SCALE,
   parameter int GAIN_FRACTION_BITS = ARS_GAIN_FRACTION_BITS
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  signed [ARS_RAW_W-1:0]    req_raw_sample,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic signed [ARS_OUT_W-1:0]    rsp_motion_value,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire         [ARS_CSR_IDX_W-1:0] csr_index,
   input  wire         [ARS_CSR_DAT_W-1:0] csr_data
);

   // Widths derived from the full scale
   localparam int MW        = $clog2(FULL_SCALE + 1);
   localparam int PROD_W    = ARS_MAG_W + ARS_SENS_W;
   localparam int CW        = (MW > ARS_GATE_W) ? MW : ARS_GATE_W;
   localparam int EW        = (MW > ARS_OUT_W) ? MW : ARS_OUT_W;
   localparam int ROM_AW    = MW + 2;
   localparam int ROM_DEPTH = 1 << ROM_AW;

   // Curve table flattened into one vector, entry k at bits [k*MW +: MW]
   typedef logic [ROM_DEPTH*MW-1:0] rom_type;

   // floor(a * b / 2^sh), low 64 bits
   function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                             input int unsigned sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[63:0] >> sh | (p[127:64] << (64 - sh));
   endfunction

   // floor(m * 2^52 / full scale)
   function automatic logic [63:0] ratio_q(input logic [63:0] m);
      logic [127:0] num;
      num = {64'd0, m} << ARS_QBITS;
      return 64'(num / 128'(FULL_SCALE));
   endfunction

   // floor(full scale * tan(a)), a in Q52, series form of sine and cosine
   function automatic logic [63:0] scaled_tan(input logic [63:0] a);
      logic [63:0]  a2;
      logic [63:0]  s;
      logic [63:0]  c;
      logic [63:0]  ts;
      logic [63:0]  tc;
      logic [63:0]  q;
      logic [64:0]  rem;
      logic [127:0] num;
      a2 = mul_shift(a, a, ARS_QBITS);
      s  = a;
      c  = 64'd1 << ARS_QBITS;
      ts = a;
      tc = 64'd1 << ARS_QBITS;
      for (int n = 1; n < ARS_SERIES_TERMS; n++) begin
         ts = mul_shift(ts, a2, ARS_QBITS) / 64'((2 * n) * (2 * n + 1));
         tc = mul_shift(tc, a2, ARS_QBITS) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            s = s - ts;
            c = c - tc;
         end else begin
            s = s + ts;
            c = c + tc;
         end
      end
      if (c == 64'd0) begin
         return 64'(FULL_SCALE);
      end
      num = {64'd0, s} << ARS_QBITS;
      // Restoring long division of the shifted sine by the cosine
      q   = '0;
      rem = '0;
      for (int i = 127; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         q   = {q[62:0], 1'b0};
         if (rem >= {1'b0, c}) begin
            rem  = rem - {1'b0, c};
            q[0] = 1'b1;
         end
      end
      return mul_shift(q, 64'(FULL_SCALE), ARS_QBITS);
   endfunction

   // Curve table: row 0 squared, 1 tangent, 2 squared tangent, 3 cubed tangent
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] m;
      logic [63:0] r;
      logic [63:0] v;
      rom = '0;
      for (int sel = 0; sel < 4; sel++) begin
         for (int i = 0; i < (1 << MW); i++) begin
            m = 64'(i);
            v = 64'd0;
            if (i <= FULL_SCALE) begin
               r = ratio_q(m);
               case (sel)
                  0: v = (m * m) / 64'(FULL_SCALE);
                  1: v = scaled_tan(r);
                  2: v = scaled_tan(mul_shift(r, r, ARS_QBITS));
                  default: v = scaled_tan(mul_shift(mul_shift(r, r, ARS_QBITS), r,
                                                    ARS_QBITS));
               endcase
               if (v > 64'(FULL_SCALE)) begin
                  v = 64'(FULL_SCALE);
               end
            end
            rom[(sel * (1 << MW) + i) * MW +: MW] = MW'(v);
         end
      end
      return rom;
   endfunction

   localparam rom_type CURVE_ROM = build_rom();

   // Configuration registers
   logic [ARS_SENS_W-1:0]  pos_sens_ff, neg_sens_ff;
   logic [ARS_CURVE_W-1:0] pos_curve_ff, neg_curve_ff;
   logic [ARS_GATE_W-1:0]  pos_gate_ff, neg_gate_ff;
   logic                   invert_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_sens_ff  <= ARS_SENS_RESET;
         neg_sens_ff  <= ARS_SENS_RESET;
         pos_curve_ff <= CURVE_LINEAR;
         neg_curve_ff <= CURVE_LINEAR;
         pos_gate_ff  <= '0;
         neg_gate_ff  <= '0;
         invert_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POS_SENS:  pos_sens_ff  <= csr_data;
            CSR_NEG_SENS:  neg_sens_ff  <= csr_data;
            CSR_POS_CURVE: pos_curve_ff <= csr_data[ARS_CURVE_W-1:0];
            CSR_NEG_CURVE: neg_curve_ff <= csr_data[ARS_CURVE_W-1:0];
            CSR_POS_GATE:  pos_gate_ff  <= csr_data[ARS_GATE_W-1:0];
            CSR_NEG_GATE:  neg_gate_ff  <= csr_data[ARS_GATE_W-1:0];
            CSR_INVERT:    invert_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline registers
   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic [ARS_MAG_W-1:0]   s1_mag_ff;
   logic [ARS_SENS_W-1:0]  s1_sens_ff;
   logic [ARS_CURVE_W-1:0] s1_curve_ff, s2_curve_ff, s3_curve_ff;
   logic [ARS_GATE_W-1:0]  s1_gate_ff, s2_gate_ff, s3_gate_ff;
   logic                   s1_neg_ff, s2_neg_ff, s3_neg_ff;
   logic [MW-1:0]          s2_m_ff, s3_m_ff, s3_rom_ff;
   logic [ARS_OUT_W-1:0]   rsp_value_ff;

   // Stage enables: a stage loads when empty or when its item moves on
   logic out_en, s3_en, s2_en, s1_en;
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s3_en     = !s3_valid_ff || out_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   // Stage 1: magnitude and side select
   logic                 raw_neg, raw_pos;
   logic [ARS_MAG_W-1:0] raw_mag;
   always_comb begin
      raw_neg = req_raw_sample[ARS_RAW_W-1];
      raw_pos = !raw_neg && (req_raw_sample != '0);
      raw_mag = raw_neg ? (ARS_MAG_W'(0) - ARS_MAG_W'(signed'(req_raw_sample)))
                        : ARS_MAG_W'(unsigned'(req_raw_sample));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_mag_ff   <= raw_mag;
         s1_sens_ff  <= raw_pos ? pos_sens_ff  : neg_sens_ff;
         s1_curve_ff <= raw_pos ? pos_curve_ff : neg_curve_ff;
         s1_gate_ff  <= raw_pos ? pos_gate_ff  : neg_gate_ff;
         s1_neg_ff   <= raw_neg ^ invert_ff;
      end
   end

   // Stage 2: gain multiply, truncate and clamp to full scale
   logic [PROD_W-1:0] prod, scaled;
   logic [MW-1:0]     m_clamped;
   always_comb begin
      prod      = PROD_W'(s1_mag_ff) * PROD_W'(s1_sens_ff);
      scaled    = prod >> GAIN_FRACTION_BITS;
      m_clamped = (scaled > PROD_W'(FULL_SCALE)) ? MW'(FULL_SCALE) : scaled[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_m_ff     <= m_clamped;
         s2_curve_ff <= s1_curve_ff;
         s2_gate_ff  <= s1_gate_ff;
         s2_neg_ff   <= s1_neg_ff;
      end
   end

   // Stage 3: curve ROM read, row picked by the curve code
   logic [1:0]        rom_row;
   logic [ROM_AW-1:0] rom_addr;
   assign rom_row  = 2'(s2_curve_ff - CURVE_SQUARED);
   assign rom_addr = {rom_row, s2_m_ff};

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_rom_ff <= CURVE_ROM[rom_addr * MW +: MW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_m_ff     <= s2_m_ff;
         s3_curve_ff <= s2_curve_ff;
         s3_gate_ff  <= s2_gate_ff;
         s3_neg_ff   <= s2_neg_ff;
      end
   end

   // Output stage: curve pick, dead band, sign and wrap to the output field
   logic [MW-1:0] shaped, gated;
   logic [EW-1:0] signed_val;
   always_comb begin
      case (s3_curve_ff) inside
         CURVE_SQUARED, CURVE_TAN, CURVE_SQ_TAN, CURVE_CUBE_TAN: shaped = s3_rom_ff;
         default: shaped = s3_m_ff;
      endcase
      gated      = (CW'(shaped) < CW'(s3_gate_ff)) ? '0 : shaped;
      signed_val = s3_neg_ff ? (EW'(0) - EW'(gated)) : EW'(gated);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_value_ff <= signed_val[ARS_OUT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motion_value = signed'(rsp_value_ff);

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the axis response shaper unit.
module tb
   import ars_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int          RANDOM_PHASES = 9;
   localparam int          PHASE_ITEMS   = 220;
   localparam int          SHOW_LIMIT    = 40;
   localparam int          DRAIN_CYCLES  = 8;
   localparam logic [ARS_CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0] Q_ONE = 64'd1 << ARS_QBITS;

   // Register shadow used by the prediction
   typedef struct packed {
      logic [ARS_SENS_W-1:0]  pos_sens;
      logic [ARS_SENS_W-1:0]  neg_sens;
      logic [ARS_CURVE_W-1:0] pos_curve;
      logic [ARS_CURVE_W-1:0] neg_curve;
      logic [ARS_GATE_W-1:0]  pos_gate;
      logic [ARS_GATE_W-1:0]  neg_gate;
      logic                   invert;
   } shaper_regs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [ARS_RAW_W-1:0]       req_raw_sample = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [ARS_OUT_W-1:0]       rsp_motion_value;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic        [ARS_CSR_IDX_W-1:0]   csr_index = '0;
   logic        [ARS_CSR_DAT_W-1:0]   csr_data = '0;

   shaper_regs_type       shaper_regs;
   logic [ARS_RAW_W-1:0]  raw_pending_q[$];
   logic [ARS_OUT_W-1:0]  expected_motion_q[$];
   logic [ARS_OUT_W-1:0]  motion_due;
   int                    req_gap_left = 0;
   int                    rsp_hold_left = 0;
   bit                    idle_on = 1'b1;
   int                    fail_count = 0;
   int unsigned           cycle_count = 0;

   axis_response_shaper_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_sample   (req_raw_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_motion_value (rsp_motion_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor(a * b / 2^52), kept to 64 bits
   function automatic logic [63:0] q52_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[ARS_QBITS+63:ARS_QBITS];
   endfunction

   // floor(FULL_SCALE * tan(ang)), ang in Q52, from truncated sin and cos series
   function automatic logic [63:0] scaled_tangent(input logic [63:0] ang);
      logic [63:0]  ang_sq, sin_acc, cos_acc, sin_term, cos_term, quot;
      logic [127:0] num;
      int           n;
      ang_sq   = q52_mul(ang, ang);
      sin_acc  = ang;
      cos_acc  = Q_ONE;
      sin_term = ang;
      cos_term = Q_ONE;
      for (n = 1; n < ARS_SERIES_TERMS; n++) begin
         sin_term = q52_mul(sin_term, ang_sq) / 64'((2 * n) * (2 * n + 1));
         cos_term = q52_mul(cos_term, ang_sq) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            sin_acc = sin_acc - sin_term;
            cos_acc = cos_acc - cos_term;
         end else begin
            sin_acc = sin_acc + sin_term;
            cos_acc = cos_acc + cos_term;
         end
      end
      if (cos_acc == 64'd0)
         return 64'(ARS_FULL_SCALE);
      num  = {64'd0, sin_acc} << ARS_QBITS;
      quot = 64'(num / {64'd0, cos_acc});
      return q52_mul(quot, 64'(ARS_FULL_SCALE));
   endfunction

   // Response curve on a clamped magnitude, result clamped to full scale
   function automatic logic [63:0] curve_magnitude(input logic [63:0] m,
                                                   input logic [ARS_CURVE_W-1:0] curve);
      logic [127:0] wide;
      logic [63:0]  ratio, v;
      wide  = {64'd0, m} << ARS_QBITS;
      ratio = 64'(wide / 128'(ARS_FULL_SCALE));
      case (curve)
         CURVE_SQUARED:  v = (m * m) / 64'(ARS_FULL_SCALE);
         CURVE_TAN:      v = scaled_tangent(ratio);
         CURVE_SQ_TAN:   v = scaled_tangent(q52_mul(ratio, ratio));
         CURVE_CUBE_TAN: v = scaled_tangent(q52_mul(q52_mul(ratio, ratio), ratio));
         default:        v = m;
      endcase
      return (v > 64'(ARS_FULL_SCALE)) ? 64'(ARS_FULL_SCALE) : v;
   endfunction

   // Shaped motion value for one raw sample under the current registers
   function automatic logic [ARS_OUT_W-1:0] predict_motion(input logic [ARS_RAW_W-1:0] raw);
      logic                   negative, positive, out_neg;
      logic [63:0]            mag, m, gate;
      logic [ARS_SENS_W-1:0]  sens;
      logic [ARS_CURVE_W-1:0] curve;
      negative = raw[ARS_RAW_W-1];
      positive = !negative && (raw != '0);
      mag      = negative ? (64'h10000 - 64'(raw)) : 64'(raw);
      sens     = positive ? shaper_regs.pos_sens  : shaper_regs.neg_sens;
      curve    = positive ? shaper_regs.pos_curve : shaper_regs.neg_curve;
      gate     = positive ? 64'(shaper_regs.pos_gate) : 64'(shaper_regs.neg_gate);
      m = (mag * 64'(sens)) >> ARS_GAIN_FRACTION_BITS;
      if (m > 64'(ARS_FULL_SCALE))
         m = 64'(ARS_FULL_SCALE);
      m = curve_magnitude(m, curve);
      if (m < gate)
         m = 64'd0;
      out_neg = negative ^ shaper_regs.invert;
      return out_neg ? ARS_OUT_W'(64'd0 - m) : ARS_OUT_W'(m);
   endfunction

   // Random sample, mostly sized so the scaled magnitude lands below full scale
   function automatic logic [ARS_RAW_W-1:0] pick_raw_sample();
      logic [ARS_RAW_W-1:0]  raw;
      logic [ARS_SENS_W-1:0] sens;
      logic                  neg;
      int unsigned           span, sel;
      sel  = $urandom_range(0, 9);
      neg  = 1'($urandom_range(0, 1));
      sens = neg ? shaper_regs.neg_sens : shaper_regs.pos_sens;
      if (sens == '0)
         span = 32767;
      else
         span = ((ARS_FULL_SCALE + 1) << ARS_GAIN_FRACTION_BITS) / sens + 1;
      if (span > 32767)
         span = 32767;
      if (sel < 7) begin
         raw = ARS_RAW_W'($urandom_range(0, span));
         if (neg)
            raw = -raw;
      end else if (sel == 7) begin
         case ($urandom_range(0, 4))
            0:       raw = 16'h7FFF;
            1:       raw = 16'h8000;
            2:       raw = 16'h0000;
            3:       raw = 16'h0001;
            default: raw = 16'hFFFF;
         endcase
      end else begin
         raw = ARS_RAW_W'($urandom);
      end
      return raw;
   endfunction

   // One register write; the shadow follows at the accepting edge
   task automatic write_reg(input logic [ARS_CSR_IDX_W-1:0] idx,
                            input logic [ARS_CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_POS_SENS:  shaper_regs.pos_sens  = data[ARS_SENS_W-1:0];
         CSR_NEG_SENS:  shaper_regs.neg_sens  = data[ARS_SENS_W-1:0];
         CSR_POS_CURVE: shaper_regs.pos_curve = data[ARS_CURVE_W-1:0];
         CSR_NEG_CURVE: shaper_regs.neg_curve = data[ARS_CURVE_W-1:0];
         CSR_POS_GATE:  shaper_regs.pos_gate  = data[ARS_GATE_W-1:0];
         CSR_NEG_GATE:  shaper_regs.neg_gate  = data[ARS_GATE_W-1:0];
         CSR_INVERT:    shaper_regs.invert    = data[0];
         default: ;
      endcase
   endtask

   // Block until every queued item went in and every result came back
   task automatic wait_drained();
      do @(negedge clock);
      while (raw_pending_q.size() != 0 || req_valid || expected_motion_q.size() != 0);
   endtask

   // Random settings for one phase; upper data bits are junk to test masking
   task automatic load_random_regs();
      logic [ARS_SENS_W-1:0] sens;
      logic [ARS_GATE_W-1:0] gate;
      int                    side;
      for (side = 0; side < 2; side++) begin
         case ($urandom_range(0, 6))
            0:       sens = 12'd0;
            1:       sens = 12'd4095;
            2:       sens = ARS_SENS_RESET;
            3:       sens = ARS_SENS_W'($urandom);
            default: sens = ARS_SENS_W'($urandom_range(16, 1024));
         endcase
         write_reg(side == 0 ? CSR_POS_SENS : CSR_NEG_SENS, sens);
         write_reg(side == 0 ? CSR_POS_CURVE : CSR_NEG_CURVE,
                   {9'($urandom), 3'($urandom_range(0, 7))});
         case ($urandom_range(0, 7))
            0:       gate = 9'd351;
            1:       gate = 9'($urandom_range(352, 511));
            2, 3:    gate = 9'($urandom_range(0, 120));
            default: gate = 9'd0;
         endcase
         write_reg(side == 0 ? CSR_POS_GATE : CSR_NEG_GATE, {3'($urandom), gate});
      end
      write_reg(CSR_INVERT, 12'($urandom));
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_UNUSED, 12'($urandom));
   endtask

   // Item driver: takes samples from the pending queue, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_motion_q.push_back(predict_motion(req_raw_sample));
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (raw_pending_q.size() != 0) begin
               req_valid      <= 1'b1;
               req_raw_sample <= raw_pending_q.pop_front();
               if (idle_on && $urandom_range(0, 7) == 0)
                  req_gap_left = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and random stall bursts on the result side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_motion_q.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("%0t: unexpected item, expected none, actual %0d",
                           $time, rsp_motion_value);
            end else begin
               motion_due = expected_motion_q.pop_front();
               if (rsp_motion_value !== motion_due) begin
                  fail_count++;
                  if (fail_count <= SHOW_LIMIT)
                     $display("%0t: motion_value mismatch, expected %0d, actual %0d",
                              $time, $signed(motion_due), rsp_motion_value);
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 9) == 0)
               rsp_hold_left = $urandom_range(1, 7);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d items still outstanding", $time,
                  expected_motion_q.size() + raw_pending_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus: directed settings first, then random phases; each phase drains
   // completely before registers change, so the sender waits on all results
   initial begin : stimulus
      int phase, k;
      shaper_regs = '{pos_sens: ARS_SENS_RESET, neg_sens: ARS_SENS_RESET,
                      pos_curve: CURVE_LINEAR, neg_curve: CURVE_LINEAR,
                      pos_gate: '0, neg_gate: '0, invert: 1'b0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: zero, unit steps, full-scale edges, field extremes
      raw_pending_q = '{16'd0, 16'd1, -16'sd1, 16'd349, 16'd350, 16'd351,
                        -16'sd350, -16'sd351, 16'h7FFF, 16'h8000};
      wait_drained();

      // max gain squared on the positive side, tangent with tiny gain on the negative
      write_reg(CSR_POS_SENS, 12'd4095);
      write_reg(CSR_NEG_SENS, 12'd1);
      write_reg(CSR_POS_CURVE, ARS_CSR_DAT_W'(CURVE_SQUARED));
      write_reg(CSR_NEG_CURVE, ARS_CSR_DAT_W'(CURVE_TAN));
      raw_pending_q = '{16'd1, 16'd86, 16'h7FFF, -16'sd1, 16'h8000, -16'sd175};
      wait_drained();

      // tangent powers, gate just above full scale, inversion
      write_reg(CSR_POS_SENS, 12'd128);
      write_reg(CSR_NEG_SENS, 12'd600);
      write_reg(CSR_POS_CURVE, ARS_CSR_DAT_W'(CURVE_SQ_TAN));
      write_reg(CSR_NEG_CURVE, ARS_CSR_DAT_W'(CURVE_CUBE_TAN));
      write_reg(CSR_POS_GATE, 12'd351);
      write_reg(CSR_NEG_GATE, 12'd100);
      write_reg(CSR_INVERT, 12'd1);
      raw_pending_q = '{16'd700, 16'h7FFF, 16'h8000, -16'sd120, 16'd0};
      wait_drained();

      // unused curve codes, zero gain, gate at 9-bit max, write to a missing register
      write_reg(CSR_POS_SENS, ARS_SENS_RESET);
      write_reg(CSR_NEG_SENS, 12'd0);
      write_reg(CSR_POS_CURVE, 12'hFFD);
      write_reg(CSR_NEG_CURVE, 12'h007);
      write_reg(CSR_POS_GATE, 12'hE00);
      write_reg(CSR_NEG_GATE, 12'h1FF);
      write_reg(CSR_INVERT, 12'hFFE);
      write_reg(CSR_UNUSED, 12'hFFF);
      raw_pending_q = '{16'd300, -16'sd300, 16'd0, 16'd12345, 16'd17};
      wait_drained();

      // random phases; one mid-run phase and the final two run without idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_regs();
         idle_on = (phase != 3) && (phase < RANDOM_PHASES - 2);
         for (k = 0; k < PHASE_ITEMS; k++)
            raw_pending_q.push_back(pick_raw_sample());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_motion_q.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected items never arrived, expected none left, actual %0d",
                  $time, expected_motion_q.size(), expected_motion_q.size());
      end
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
